// File: hdl/key_debounce_autorepeat_core_macros.svh
// Assertion macros for the key debounce and auto-repeat block.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_CORE_MACROS_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge.
`define KDA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kda assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge.
`define KDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kda assertion failed: next-cycle implication");

`endif

// File: hdl/kda_pkg.sv
// Shared types and constants of the key debounce and auto-repeat block.
package kda_pkg;

   localparam int NUM_KEYS         = 4;
   localparam int HOLD_W           = 10;
   localparam int REPEAT_W         = 8;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 10;

   localparam logic [HOLD_W-1:0]   HOLD_TICKS_RESET    = HOLD_W'(100);
   localparam logic [REPEAT_W-1:0] REPEAT_TICKS_RESET  = REPEAT_W'(25);
   localparam logic                PRESSED_LEVEL_RESET = 1'b0;
   localparam logic [NUM_KEYS-1:0] REPEAT_MASK_RESET   = NUM_KEYS'(6);

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_READ = 1'b1
   } kda_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_TICKS    = 2'd0,
      CSR_REPEAT_TICKS  = 2'd1,
      CSR_PRESSED_LEVEL = 2'd2,
      CSR_REPEAT_MASK   = 2'd3
   } kda_csr_index_type;

   // Configuration as seen by one key lane
   typedef struct packed {
      logic [HOLD_W-1:0]   hold_ticks;
      logic [REPEAT_W-1:0] repeat_ticks;
      logic                pressed_level;
      logic                repeat_en;
   } kda_lane_cfg_type;

   // Per-key command for the accepted transaction
   typedef struct packed {
      logic tick;
      logic read;
      logic raw;
      logic clear;
   } kda_key_cmd_type;

   // What one lane reports for the accepted transaction
   typedef struct packed {
      logic flag;
      logic level;
   } kda_key_report_type;

endpackage

// File: hdl/kda_if.sv
// Handshake channel interfaces: request, response and register write.
interface kda_req_if import kda_pkg::*; ();
   logic                valid;
   logic                ready;
   kda_op_type          op;
   logic [NUM_KEYS-1:0] raw_levels;
   logic [NUM_KEYS-1:0] clear_mask;

   modport source (output valid, output op, output raw_levels, output clear_mask,
                   input ready);
   modport sink   (input valid, input op, input raw_levels, input clear_mask,
                   output ready);
endinterface

interface kda_rsp_if import kda_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NUM_KEYS-1:0] press_flags;
   logic [NUM_KEYS-1:0] stable_levels;

   modport source (output valid, output press_flags, output stable_levels, input ready);
   modport sink   (input valid, input press_flags, input stable_levels, output ready);
endinterface

interface kda_csr_if import kda_pkg::*; ();
   logic                  valid;
   logic                  ready;
   kda_csr_index_type     index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/kda_lane.sv
// One key lane: sample line, debounced level, hold and repeat counters, event flag.
module kda_lane import kda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  kda_lane_cfg_type   cfg,
   input  kda_key_cmd_type    cmd,
   output kda_key_report_type report
);

   logic                newest_ff, newest_in;
   logic                middle_ff, middle_in;
   logic                oldest_ff, oldest_in;
   logic                stable_ff, stable_in;
   logic                flag_ff, flag_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic [REPEAT_W-1:0] repeat_ff, repeat_in;
   logic [REPEAT_W-1:0] repeat_dec;

   always_comb begin
      newest_in  = newest_ff;
      middle_in  = middle_ff;
      oldest_in  = oldest_ff;
      stable_in  = stable_ff;
      flag_in    = flag_ff;
      hold_in    = hold_ff;
      repeat_in  = repeat_ff;
      repeat_dec = repeat_ff;

      if (cmd.tick) begin
         newest_in = cmd.raw;
         middle_in = newest_ff;
         oldest_in = middle_ff;
         // Three agreeing samples qualify a level
         if (newest_in == middle_in && middle_in == oldest_in) begin
            if (oldest_in != stable_ff) begin
               stable_in = oldest_in;
               hold_in   = '0;
               repeat_in = cfg.repeat_ticks;
               if (oldest_in == cfg.pressed_level) begin
                  flag_in = 1'b1;
               end
            end else if (stable_ff == cfg.pressed_level) begin
               if (hold_ff < cfg.hold_ticks) begin
                  hold_in = hold_ff + HOLD_W'(1);
                  if (hold_in == cfg.hold_ticks) begin
                     repeat_in = '0;
                  end
               end else begin
                  if (repeat_ff != '0) begin
                     repeat_dec = repeat_ff - REPEAT_W'(1);
                  end
                  repeat_in = repeat_dec;
                  if (repeat_dec == '0) begin
                     repeat_in = cfg.repeat_ticks;
                     if (cfg.repeat_en) begin
                        flag_in = 1'b1;
                     end
                  end
               end
            end
         end
      end else if (cmd.read) begin
         flag_in = flag_ff & ~cmd.clear;
      end
   end

   // Tick reports the updated flag, read reports it before clearing
   assign report.flag  = cmd.tick ? flag_in : flag_ff;
   assign report.level = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= ~PRESSED_LEVEL_RESET;
         middle_ff <= ~PRESSED_LEVEL_RESET;
         oldest_ff <= ~PRESSED_LEVEL_RESET;
         stable_ff <= ~PRESSED_LEVEL_RESET;
         flag_ff   <= 1'b0;
         hold_ff   <= '0;
         repeat_ff <= REPEAT_TICKS_RESET;
      end else begin
         newest_ff <= newest_in;
         middle_ff <= middle_in;
         oldest_ff <= oldest_in;
         stable_ff <= stable_in;
         flag_ff   <= flag_in;
         hold_ff   <= hold_in;
         repeat_ff <= repeat_in;
      end
   end

endmodule

// File: hdl/kda_merge.sv
// Merge stage: gathers lane reports into one response and buffers it two deep.
module kda_merge import kda_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  kda_key_report_type  reports [NUM_KEYS],
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [NUM_KEYS-1:0] out_flags,
   output logic [NUM_KEYS-1:0] out_levels
);

   logic [NUM_KEYS-1:0] new_flags;
   logic [NUM_KEYS-1:0] new_levels;

   logic                out_valid_ff, out_valid_in;
   logic [NUM_KEYS-1:0] out_flags_ff, out_flags_in;
   logic [NUM_KEYS-1:0] out_levels_ff, out_levels_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [NUM_KEYS-1:0] skid_flags_ff, skid_flags_in;
   logic [NUM_KEYS-1:0] skid_levels_ff, skid_levels_in;
   logic                take;

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         new_flags[k]  = reports[k].flag;
         new_levels[k] = reports[k].level;
      end
   end

   assign take     = out_valid_ff && out_ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_flags_in   = out_flags_ff;
      out_levels_in  = out_levels_ff;
      skid_valid_in  = skid_valid_ff;
      skid_flags_in  = skid_flags_ff;
      skid_levels_in = skid_levels_ff;

      priority if (skid_valid_ff) begin
         // Input is held off; drain the skid entry once the output frees up
         if (take) begin
            out_flags_in  = skid_flags_ff;
            out_levels_in = skid_levels_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_in  = 1'b1;
            out_flags_in  = new_flags;
            out_levels_in = new_levels;
         end else begin
            skid_valid_in  = 1'b1;
            skid_flags_in  = new_flags;
            skid_levels_in = new_levels;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_flags_ff   <= out_flags_in;
      out_levels_ff  <= out_levels_in;
      skid_flags_ff  <= skid_flags_in;
      skid_levels_ff <= skid_levels_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_flags  = out_flags_ff;
   assign out_levels = out_levels_ff;

endmodule

// File: hdl/key_debounce_autorepeat_core.sv
// Top level of the key debounce and auto-repeat block.
//
// Four button lines, one lane per key, all updated by the same transaction.
// req_bus: op selects a sample tick (raw_levels shifted in) or a read of
//   the event flags (flags in clear_mask cleared after reporting).
// rsp_bus: one response per request: press_flags and stable_levels.
// csr_bus: register writes (hold_ticks, repeat_ticks, pressed_level,
//   repeat_enable_mask); always ready, write only while the block is idle.
// Response: valid the cycle after acceptance unless held in the skid entry.
// Throughput: one request per cycle unless stalled; every lane does its compare
//   and counter update in the accepting cycle; the merge stage registers the result.
// Stall: a two-entry output buffer keeps taking requests while one response
//   waits; with both entries full req_bus.ready drops until rsp_bus drains.
// Reset: samples and stable levels go to the released level, flags and hold
//   counters clear, repeat counters and registers load defaults, buffer empties.
module key_debounce_autorepeat_core import kda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   kda_req_if.sink   req_bus,
   kda_rsp_if.source rsp_bus,
   kda_csr_if.sink   csr_bus
);

   logic [HOLD_W-1:0]   hold_ticks_ff;
   logic [REPEAT_W-1:0] repeat_ticks_ff;
   logic                pressed_level_ff;
   logic [NUM_KEYS-1:0] repeat_mask_ff;

   logic               req_accept;
   logic               merge_ready;
   kda_key_report_type reports [NUM_KEYS];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff    <= HOLD_TICKS_RESET;
         repeat_ticks_ff  <= REPEAT_TICKS_RESET;
         pressed_level_ff <= PRESSED_LEVEL_RESET;
         repeat_mask_ff   <= REPEAT_MASK_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_bus.data[HOLD_W-1:0];
            CSR_REPEAT_TICKS:  repeat_ticks_ff  <= csr_bus.data[REPEAT_W-1:0];
            CSR_PRESSED_LEVEL: pressed_level_ff <= csr_bus.data[0];
            CSR_REPEAT_MASK:   repeat_mask_ff   <= csr_bus.data[NUM_KEYS-1:0];
         endcase
      end
   end

   assign req_bus.ready = merge_ready;
   assign req_accept    = req_bus.valid && merge_ready;

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kda_lane_cfg_type lane_cfg;
      kda_key_cmd_type  lane_cmd;

      assign lane_cfg.hold_ticks    = hold_ticks_ff;
      assign lane_cfg.repeat_ticks  = repeat_ticks_ff;
      assign lane_cfg.pressed_level = pressed_level_ff;
      assign lane_cfg.repeat_en     = repeat_mask_ff[k];

      assign lane_cmd.tick  = req_accept && (req_bus.op == OP_TICK);
      assign lane_cmd.read  = req_accept && (req_bus.op == OP_READ);
      assign lane_cmd.raw   = req_bus.raw_levels[k];
      assign lane_cmd.clear = req_bus.clear_mask[k];

      kda_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .cfg    (lane_cfg),
         .cmd    (lane_cmd),
         .report (reports[k])
      );
   end

   kda_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .reports    (reports),
      .in_ready   (merge_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_flags  (rsp_bus.press_flags),
      .out_levels (rsp_bus.stable_levels)
   );

endmodule

// File: hdl/kda_checker.sv
// Port-level checks for the key debounce and auto-repeat block, bound to the top level.
`include "key_debounce_autorepeat_core_macros.svh"

module kda_checker import kda_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_valid,
   input logic csr_ready
);

   // A stalled response stays offered
   `KDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Every accepted request has a response waiting in the next cycle
   `KDA_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)

   // The buffer comes out of reset empty
   `KDA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

   // Register writes never stall
   `KDA_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind key_debounce_autorepeat_core kda_checker u_kda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);

// File: test/key_debounce_autorepeat_core_tb.sv
// Self-checking testbench of the key debounce and auto-repeat block.
`timescale 1ns / 100ps

module key_debounce_autorepeat_core_tb;
   import kda_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int MAX_REPORTED   = 10;

   typedef struct packed {
      logic [NUM_KEYS-1:0] press_flags;
      logic [NUM_KEYS-1:0] stable_levels;
   } key_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kda_req_if req_bus ();
   kda_rsp_if rsp_bus ();
   kda_csr_if csr_bus ();

   key_debounce_autorepeat_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted configuration and per-key state
   logic [HOLD_W-1:0]   cfg_hold_ticks;
   logic [REPEAT_W-1:0] cfg_repeat_ticks;
   logic                cfg_pressed_level;
   logic [NUM_KEYS-1:0] cfg_repeat_mask;
   logic [NUM_KEYS-1:0] smp_newest, smp_middle, smp_oldest, debounced;
   logic [HOLD_W-1:0]   hold_cnt [NUM_KEYS];
   logic [REPEAT_W-1:0] repeat_cnt [NUM_KEYS];
   logic [NUM_KEYS-1:0] press_events;

   key_report_type pending_reports [$];
   int mismatches    = 0;
   int idle_cycles   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int phase_items   = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic key_report_type predict_report(kda_op_type op,
                                                     logic [NUM_KEYS-1:0] raw,
                                                     logic [NUM_KEYS-1:0] clr);
      key_report_type rep;
      if (op == OP_TICK) begin
         smp_oldest = smp_middle;
         smp_middle = smp_newest;
         smp_newest = raw;
         for (int k = 0; k < NUM_KEYS; k++) begin
            // act only when all three samples agree
            if (smp_newest[k] == smp_middle[k] && smp_middle[k] == smp_oldest[k]) begin
               if (smp_oldest[k] != debounced[k]) begin
                  debounced[k]  = smp_oldest[k];
                  hold_cnt[k]   = '0;
                  repeat_cnt[k] = cfg_repeat_ticks;
                  if (smp_oldest[k] == cfg_pressed_level) press_events[k] = 1'b1;
               end else if (debounced[k] == cfg_pressed_level) begin
                  if (hold_cnt[k] < cfg_hold_ticks) begin
                     hold_cnt[k] = hold_cnt[k] + HOLD_W'(1);
                     if (hold_cnt[k] == cfg_hold_ticks) repeat_cnt[k] = '0;
                  end else begin
                     if (repeat_cnt[k] != '0) repeat_cnt[k] = repeat_cnt[k] - REPEAT_W'(1);
                     if (repeat_cnt[k] == '0) begin
                        repeat_cnt[k] = cfg_repeat_ticks;
                        if (cfg_repeat_mask[k]) press_events[k] = 1'b1;
                     end
                  end
               end
            end
         end
         rep.press_flags = press_events;
      end else begin
         rep.press_flags = press_events;
         press_events    = press_events & ~clr;
      end
      rep.stable_levels = debounced;
      return rep;
   endfunction

   task automatic report_mismatch(string field, logic [NUM_KEYS-1:0] want,
                                  logic [NUM_KEYS-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
         $display("mismatch %s: expected %h, got %h", field, want, got);
   endtask

   task automatic send_item(kda_op_type op, logic [NUM_KEYS-1:0] raw,
                            logic [NUM_KEYS-1:0] clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.raw_levels <= raw;
      req_bus.clear_mask <= clr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_reports.push_back(predict_report(op, raw, clr));
      phase_items++;
   endtask

   // Drop valid and hold until every response is back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(kda_csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_HOLD_TICKS:    cfg_hold_ticks    = value[HOLD_W-1:0];
         CSR_REPEAT_TICKS:  cfg_repeat_ticks  = value[REPEAT_W-1:0];
         CSR_PRESSED_LEVEL: cfg_pressed_level = value[0];
         CSR_REPEAT_MASK:   cfg_repeat_mask   = value[NUM_KEYS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(logic [HOLD_W-1:0] hold, logic [REPEAT_W-1:0] rep,
                               logic level, logic [NUM_KEYS-1:0] mask);
      wait_idle();
      csr_write(CSR_HOLD_TICKS, CSR_DATA_W'(hold));
      csr_write(CSR_REPEAT_TICKS, CSR_DATA_W'(rep));
      csr_write(CSR_PRESSED_LEVEL, CSR_DATA_W'(level));
      csr_write(CSR_REPEAT_MASK, CSR_DATA_W'(mask));
      csr_bus.valid <= 1'b0;
   endtask

   // Default registers: press, bounce, read with clearing, ignored fields
   task automatic test_press_and_read();
      send_item(OP_TICK, 4'hF, 4'hF);
      repeat (3) send_item(OP_TICK, 4'h0, 4'h0);
      send_item(OP_READ, 4'hF, 4'h0);
      send_item(OP_READ, 4'h0, 4'h5);
      send_item(OP_TICK, 4'h0, 4'hF);
      send_item(OP_READ, 4'h5, 4'hF);
      send_item(OP_TICK, 4'h5, 4'h0);
      send_item(OP_TICK, 4'h0, 4'h0);
   endtask

   // Zero hold and zero repeat: a flag on every stable pressed tick
   task automatic test_zero_intervals();
      write_config('0, '0, 1'b0, 4'hF);
      repeat (3) send_item(OP_TICK, 4'hF, 4'h0);
      repeat (3) send_item(OP_TICK, 4'h0, 4'h0);
      send_item(OP_READ, 4'h0, 4'hF);
      send_item(OP_TICK, 4'h0, 4'h0);
      send_item(OP_READ, 4'h0, 4'hF);
   endtask

   // Flip the pressed level, then lower the hold below a running count
   task automatic test_level_swap();
      write_config(HOLD_W'(1000), REPEAT_W'(3), 1'b1, 4'hF);
      repeat (3) send_item(OP_TICK, 4'hF, 4'h0);
      send_item(OP_READ, 4'h0, 4'hF);
      repeat (2) send_item(OP_TICK, 4'hF, 4'h0);
      write_config(HOLD_W'(1), REPEAT_W'(3), 1'b1, 4'h6);
      repeat (3) send_item(OP_TICK, 4'hF, 4'h0);
      send_item(OP_READ, 4'h0, 4'hF);
   endtask

   task automatic test_random_phase(int phase, logic [HOLD_W-1:0] hold,
                                    logic [REPEAT_W-1:0] rep, logic level,
                                    logic [NUM_KEYS-1:0] mask, int n_items);
      logic [NUM_KEYS-1:0] target;
      int span;
      case (phase % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 70; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 70; end
         default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      write_config(hold, rep, level, mask);
      phase_items = 0;
      target = {NUM_KEYS{~level}};
      while (phase_items < n_items) begin
         if ($urandom_range(99) < 70) begin
            // steady level for a random span of up to 3 + hold + 3 * rep items, capped at 24
            if ($urandom_range(1) == 1) target = NUM_KEYS'($urandom_range(15));
            span = 3 + hold + 3 * rep;
            if (span > 24) span = 24;
            span = $urandom_range(3, span);
            for (int j = 0; j < span && phase_items < n_items; j++) begin
               if ($urandom_range(99) < 20)
                  send_item(OP_READ, NUM_KEYS'($urandom_range(15)),
                            NUM_KEYS'($urandom_range(15)));
               else if (j < 2 && $urandom_range(99) < 30)
                  send_item(OP_TICK, target ^ NUM_KEYS'($urandom_range(1, 15)),
                            NUM_KEYS'($urandom_range(15)));
               else
                  send_item(OP_TICK, target, NUM_KEYS'($urandom_range(15)));
            end
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(kda_op_type'($urandom_range(1)), NUM_KEYS'($urandom_range(15)),
                         NUM_KEYS'($urandom_range(15)));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      key_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("response with nothing expected", '0, rsp_bus.press_flags);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_bus.press_flags !== want.press_flags)
               report_mismatch("press_flags", want.press_flags, rsp_bus.press_flags);
            if (rsp_bus.stable_levels !== want.stable_levels)
               report_mismatch("stable_levels", want.stable_levels, rsp_bus.stable_levels);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("key_debounce_autorepeat_core test failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_TICK;
      req_bus.raw_levels <= '0;
      req_bus.clear_mask <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_HOLD_TICKS;
      csr_bus.data       <= '0;

      cfg_hold_ticks    = HOLD_TICKS_RESET;
      cfg_repeat_ticks  = REPEAT_TICKS_RESET;
      cfg_pressed_level = PRESSED_LEVEL_RESET;
      cfg_repeat_mask   = REPEAT_MASK_RESET;
      smp_newest   = {NUM_KEYS{~PRESSED_LEVEL_RESET}};
      smp_middle   = {NUM_KEYS{~PRESSED_LEVEL_RESET}};
      smp_oldest   = {NUM_KEYS{~PRESSED_LEVEL_RESET}};
      debounced    = {NUM_KEYS{~PRESSED_LEVEL_RESET}};
      press_events = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         hold_cnt[k]   = '0;
         repeat_cnt[k] = REPEAT_TICKS_RESET;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_press_and_read();
      test_zero_intervals();
      test_level_swap();
      test_random_phase(0, HOLD_W'(1), REPEAT_W'(1), 1'b0, 4'hF, 80);
      test_random_phase(1, HOLD_W'(4), REPEAT_W'(2), 1'b1, 4'h5, 80);
      test_random_phase(2, HOLD_W'(1023), REPEAT_W'(255), 1'b0, 4'hF, 80);
      test_random_phase(3, HOLD_W'(0), REPEAT_W'(0), 1'b1, 4'hA, 80);
      test_random_phase(4, HOLD_W'($urandom_range(1, 6)), REPEAT_W'($urandom_range(1, 4)),
                        1'($urandom_range(1)), 4'h0, 80);
      test_random_phase(5, HOLD_W'($urandom_range(1, 6)), REPEAT_W'($urandom_range(1, 4)),
                        1'($urandom_range(1)), NUM_KEYS'($urandom_range(15)), 80);
      test_random_phase(6, HOLD_W'($urandom_range(1, 6)), REPEAT_W'($urandom_range(1, 4)),
                        1'($urandom_range(1)), NUM_KEYS'($urandom_range(15)), 80);
      test_random_phase(7, HOLD_W'($urandom_range(1, 6)), REPEAT_W'($urandom_range(1, 4)),
                        1'($urandom_range(1)), NUM_KEYS'($urandom_range(15)), 80);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("key_debounce_autorepeat_core test passed");
      end else begin
         $display("key_debounce_autorepeat_core test failed");
      end
      $finish;
   end

endmodule
